// File: design/sfsp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfsp_pkg
// shared types and codes of the shutter and focus sequence player
// ----------------------------------------------------------------------------
package sfsp_pkg;

  localparam int SEQ_LEN_DEF = 32;
  localparam int TICK_MS_DEF = 1;

  localparam int OPER_W  = 2;
  localparam int INDEX_W = 5;
  localparam int BYTE_W  = 8;
  localparam int STOP_W  = 2;
  localparam int MS_W    = 16;

  // operation codes on the input side
  localparam logic [OPER_W-1:0] OPER_WRITE = 2'd0;
  localparam logic [OPER_W-1:0] OPER_START = 2'd1;
  localparam logic [OPER_W-1:0] OPER_TICK  = 2'd2;

  // program opcodes
  localparam logic [BYTE_W-1:0] OP_END         = 8'd0;
  localparam logic [BYTE_W-1:0] OP_FOCUS_ON    = 8'd1;
  localparam logic [BYTE_W-1:0] OP_FOCUS_OFF   = 8'd2;
  localparam logic [BYTE_W-1:0] OP_SHUTTER_ON  = 8'd3;
  localparam logic [BYTE_W-1:0] OP_SHUTTER_OFF = 8'd4;
  localparam logic [BYTE_W-1:0] OP_DELAY       = 8'd5;

  // stop causes
  localparam logic [STOP_W-1:0] STOP_NONE      = 2'd0;
  localparam logic [STOP_W-1:0] STOP_END       = 2'd1;
  localparam logic [STOP_W-1:0] STOP_UNKNOWN   = 2'd2;
  localparam logic [STOP_W-1:0] STOP_EXHAUSTED = 2'd3;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_WRITE,
    KIND_START,
    KIND_TICK
  } kind_t;

  typedef struct packed {
    kind_t               kind;
    logic [INDEX_W-1:0]  index;
    logic [BYTE_W-1:0]   value;
  } item_t;

  // head of the queue between front and back
  typedef struct packed {
    logic  valid;
    item_t item;
  } head_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_EXEC,
    ST_LO,
    ST_HI,
    ST_DONE
  } state_t;

endpackage

// File: design/sfsp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfsp_front
// takes input words, classifies them and holds them in a two-entry queue
// ----------------------------------------------------------------------------
module sfsp_front #(
  parameter int SEQ_LEN = sfsp_pkg::SEQ_LEN_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [sfsp_pkg::OPER_W-1:0]   in_oper,
  input  logic [sfsp_pkg::INDEX_W-1:0]  in_index,
  input  logic [sfsp_pkg::BYTE_W-1:0]   in_value,
  output sfsp_pkg::head_t               head,
  input  logic                          pop
);
  import sfsp_pkg::*;

  item_t      slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  item_t      item_in;

  // classify: out-of-range writes and the unused code become no-op items
  always_comb begin
    item_in.index = in_index;
    item_in.value = in_value;
    case (in_oper)
      OPER_WRITE: item_in.kind = (32'(in_index) < 32'(SEQ_LEN)) ? KIND_WRITE : KIND_NONE;
      OPER_START: item_in.kind = KIND_START;
      OPER_TICK:  item_in.kind = KIND_TICK;
      default:    item_in.kind = KIND_NONE;
    endcase
  end

  assign in_ready   = (count != 2'd2);
  assign push       = in_valid && in_ready;
  assign head.valid = (count != 2'd0);
  assign head.item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: design/sfsp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfsp_back
// program store and command sequencer with a registered result word
// ----------------------------------------------------------------------------
module sfsp_back #(
  parameter int SEQ_LEN = sfsp_pkg::SEQ_LEN_DEF,
  parameter int TICK_MS = sfsp_pkg::TICK_MS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  sfsp_pkg::head_t  head,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       out_data
);
  import sfsp_pkg::*;

  localparam int AW = (SEQ_LEN > 1) ? $clog2(SEQ_LEN) : 1;
  localparam int PW = $clog2(SEQ_LEN + 1);
  localparam logic [MS_W-1:0] TickMs = MS_W'(TICK_MS);

  logic [BYTE_W-1:0] mem [SEQ_LEN];
  logic [BYTE_W-1:0] rd_data;
  logic              mem_we;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;

  state_t            state, state_next;
  logic [PW-1:0]     pc, pc_next;
  logic [MS_W-1:0]   rem, rem_next;
  logic              running, running_next;
  logic              focus, focus_next;
  logic              shutter, shutter_next;
  logic [STOP_W-1:0] last_stop, last_stop_next;
  logic [BYTE_W-1:0] lo, lo_next;
  logic              out_load;

  logic [MS_W-1:0]   rem_sub;
  logic [MS_W-1:0]   ms;
  logic              pc_end;
  logic              delay_past;
  logic              out_free;

  assign rem_sub    = rem - TickMs;
  assign ms         = {rd_data, lo};
  assign pc_end     = (pc >= PW'(SEQ_LEN));
  assign delay_past = (({1'b0, pc} + (PW+1)'(2)) > (PW+1)'(SEQ_LEN));
  assign out_free   = !out_valid || out_ready;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (head.valid) begin
          case (head.item.kind)
            KIND_START: state_next = running ? ST_DONE : ST_FETCH;
            KIND_TICK:  state_next = (running && rem_sub < TickMs) ? ST_FETCH : ST_DONE;
            default:    state_next = ST_DONE;
          endcase
        end
      end
      ST_FETCH: state_next = pc_end ? ST_DONE : ST_EXEC;
      ST_EXEC: begin
        case (rd_data)
          OP_FOCUS_ON, OP_FOCUS_OFF, OP_SHUTTER_ON, OP_SHUTTER_OFF: state_next = ST_FETCH;
          OP_DELAY: state_next = delay_past ? ST_DONE : ST_LO;
          default:  state_next = ST_DONE;
        endcase
      end
      ST_LO:   state_next = ST_HI;
      ST_HI:   state_next = (ms < TickMs) ? ST_FETCH : ST_DONE;
      ST_DONE: state_next = out_free ? ST_IDLE : ST_DONE;
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    pop            = 1'b0;
    mem_we         = 1'b0;
    rd_en          = 1'b0;
    rd_addr        = pc[AW-1:0];
    out_load       = 1'b0;
    pc_next        = pc;
    rem_next       = rem;
    running_next   = running;
    focus_next     = focus;
    shutter_next   = shutter;
    last_stop_next = last_stop;
    lo_next        = lo;
    case (state)
      ST_IDLE: begin
        if (head.valid) begin
          pop = 1'b1;
          case (head.item.kind)
            KIND_WRITE: mem_we = 1'b1;
            KIND_START: begin
              if (!running) begin
                pc_next        = '0;
                last_stop_next = STOP_NONE;
              end
            end
            KIND_TICK: begin
              if (running) begin
                rem_next = rem_sub;
                if (rem_sub < TickMs) begin
                  running_next = 1'b0;
                end
              end
            end
            default: ;
          endcase
        end
      end
      ST_FETCH: begin
        if (pc_end) begin
          running_next   = 1'b0;
          rem_next       = '0;
          last_stop_next = STOP_EXHAUSTED;
        end else begin
          rd_en   = 1'b1;
          pc_next = pc + PW'(1);
        end
      end
      ST_EXEC: begin
        case (rd_data)
          OP_FOCUS_ON:    focus_next   = 1'b1;
          OP_FOCUS_OFF:   focus_next   = 1'b0;
          OP_SHUTTER_ON:  shutter_next = 1'b1;
          OP_SHUTTER_OFF: shutter_next = 1'b0;
          OP_DELAY: begin
            if (delay_past) begin
              running_next   = 1'b0;
              rem_next       = '0;
              last_stop_next = STOP_EXHAUSTED;
            end else begin
              rd_en   = 1'b1;
              pc_next = pc + PW'(1);
            end
          end
          OP_END: begin
            running_next   = 1'b0;
            rem_next       = '0;
            last_stop_next = STOP_END;
          end
          default: begin
            running_next   = 1'b0;
            rem_next       = '0;
            last_stop_next = STOP_UNKNOWN;
          end
        endcase
      end
      ST_LO: begin
        lo_next = rd_data;
        rd_en   = 1'b1;
        pc_next = pc + PW'(1);
      end
      ST_HI: begin
        if (ms >= TickMs) begin
          rem_next     = ms;
          running_next = 1'b1;
        end
      end
      ST_DONE: out_load = out_free;
      default: ;
    endcase
  end

  // program store, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[AW'(head.item.index)] <= head.item.value;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    lo <= lo_next;
    if (out_load) begin
      out_data <= {3'b000, last_stop, running, shutter, focus};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      pc        <= '0;
      rem       <= '0;
      running   <= 1'b0;
      focus     <= 1'b0;
      shutter   <= 1'b0;
      last_stop <= STOP_NONE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      pc        <= pc_next;
      rem       <= rem_next;
      running   <= running_next;
      focus     <= focus_next;
      shutter   <= shutter_next;
      last_stop <= last_stop_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: design/shutter_focus_sequence_player.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shutter_focus_sequence_player
// cable-release sequencer: byte program store, run on start, delays on ticks
// ----------------------------------------------------------------------------
// results: a write, a tick inside a delay or an ignored word gives its result
//   word through the IDLE and DONE states; a run steps each one-byte command
//   through FETCH and EXEC, and a delay command also through LO and HI
// flow: one word at a time through the sequencer; the next word is popped
//   only after the result word of the last one has been loaded
// reset: control state, line levels and stop cause cleared; the program store
//   keeps no reset value and is undefined until written, no clearing pass
module shutter_focus_sequence_player #(
  parameter int SEQ_LEN = sfsp_pkg::SEQ_LEN_DEF,
  parameter int TICK_MS = sfsp_pkg::TICK_MS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // index[4:0], byte_value[12:5], zero pad
  input  logic [1:0]  s_axis_tuser,   // operation[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata    // focus_level[0], shutter_level[1],
                                      // busy_res[2], stop_cause[4:3], zero pad
);
  import sfsp_pkg::*;

  head_t head;
  logic  pop;

  // front: classifies incoming words and queues them
  sfsp_front #(
    .SEQ_LEN (SEQ_LEN)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_oper  (s_axis_tuser),
    .in_index (s_axis_tdata[4:0]),
    .in_value (s_axis_tdata[12:5]),
    .head     (head),
    .pop      (pop)
  );

  // back: store, sequencer and result register
  sfsp_back #(
    .SEQ_LEN (SEQ_LEN),
    .TICK_MS (TICK_MS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .pop       (pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );

  // the sequencer never takes from an empty queue
  assert property (@(posedge clk) disable iff (rst) pop |-> head.valid)
    else $error("pop from empty queue");

  // the front only stalls when the queue holds work
  assert property (@(posedge clk) disable iff (rst) !s_axis_tready |-> head.valid)
    else $error("front stalled with empty queue");

  // a run waiting in a delay has no stop cause
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[2]) |-> (m_axis_tdata[4:3] == STOP_NONE))
    else $error("busy with stop cause set");

  // pops never come back to back; each popped item gets its result word first
  assert property (@(posedge clk) disable iff (rst) pop |=> !pop)
    else $error("back-to-back pops");

endmodule
